// File: design/accov_pkg.sv
// Shared constants, widths and the arctangent table for the orientation block.
// No dependencies.
`timescale 1ns / 1ps

package accov_pkg;

    localparam int CORDIC_STEPS_DEFAULT = 16;
    localparam int ATAN_TABLE_LEN       = 24;
    localparam int ROOT_STEPS           = 24;   // two radicand bits per step, 48-bit radicand
    localparam int CNT_W                = 5;

    localparam logic [1:0]  AXIS_X = 2'd0;
    localparam logic [1:0]  AXIS_Y = 2'd1;
    localparam logic [1:0]  AXIS_Z = 2'd2;

    localparam logic [1:0]  REG_NORMAL_AXIS     = 2'd0;
    localparam logic [1:0]  REG_NORMAL_NEGATIVE = 2'd1;
    localparam logic [1:0]  REG_THRESHOLD       = 2'd2;

    localparam logic [1:0]  AXIS_RESET      = AXIS_Z;
    localparam logic [15:0] THRESHOLD_RESET = 16'd12288;

    localparam logic [3:0] POS_UPRIGHT  = 4'd0;
    localparam logic [3:0] POS_INVERTED = 4'd1;
    localparam logic [3:0] POS_Z_POS    = 4'd2;
    localparam logic [3:0] POS_Z_NEG    = 4'd3;
    localparam logic [3:0] POS_X_POS    = 4'd4;
    localparam logic [3:0] POS_X_NEG    = 4'd5;
    localparam logic [3:0] POS_Y_POS    = 4'd6;
    localparam logic [3:0] POS_Y_NEG    = 4'd7;
    localparam logic [3:0] POS_TILTED   = 4'd8;

    // 90 degrees in 1/4096 centidegree
    localparam logic signed [28:0] DEG90 = 29'sd36864000;

    // atan(2^-i) in 1/4096 centidegree
    function automatic logic [24:0] atan_entry(input logic [CNT_W-1:0] i);
        logic [24:0] v;
        unique case (i)
            5'd0:  v = 25'd18432000;
            5'd1:  v = 25'd10881045;
            5'd2:  v = 25'd5749245;
            5'd3:  v = 25'd2918407;
            5'd4:  v = 25'd1464867;
            5'd5:  v = 25'd733147;
            5'd6:  v = 25'd366663;
            5'd7:  v = 25'd183343;
            5'd8:  v = 25'd91673;
            5'd9:  v = 25'd45837;
            5'd10: v = 25'd22918;
            5'd11: v = 25'd11459;
            5'd12: v = 25'd5730;
            5'd13: v = 25'd2865;
            5'd14: v = 25'd1432;
            5'd15: v = 25'd716;
            5'd16: v = 25'd358;
            5'd17: v = 25'd179;
            5'd18: v = 25'd90;
            5'd19: v = 25'd45;
            5'd20: v = 25'd22;
            5'd21: v = 25'd11;
            5'd22: v = 25'd6;
            5'd23: v = 25'd3;
            default: v = 25'd0;
        endcase
        return v;
    endfunction

endpackage

// File: design/accel_orientation_vibration.sv
// Accelerometer tilt, pitch, roll, position and vibration block.
// A sample is captured, its axes squared, three square roots taken and three angles rotated
// out by CORDIC before the result is registered; an angle whose operands give zero directly
// skips its CORDIC iterations. It uses one shared multiplier, one two-bit-per-cycle square-root
// unit and one CORDIC unit. Input is ready only while the sequencer is idle, so no new sample
// is taken before the last is finished, and a result still waiting holds the sequencer.
// Reset: asynchronous, active low; registers return to Z normal, threshold 12288, and
// the vibration history is cleared so the first sample reports zero.
// Depends on accov_pkg.
`timescale 1ns / 1ps

module accel_orientation_vibration
    import accov_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // accel_x, accel_y, accel_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tilt_centideg, tilt_valid, pitch_centideg, roll_centideg, position_code,
    // vibration, zero pad
    output logic [71:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int STEPS_USED = (CORDIC_STEPS > ATAN_TABLE_LEN) ? ATAN_TABLE_LEN : CORDIC_STEPS;
    localparam logic [CNT_W-1:0] ROT_LAST  = CNT_W'(STEPS_USED - 1);
    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_STEPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SQUARE, ST_ROOT_LOAD, ST_ROOT_STEP,
        ST_ROT_LOAD, ST_ROT_STEP, ST_ROT_DONE, ST_FINISH
    } state_t;

    state_t state_reg;
    logic [1:0]  axis_reg;
    logic        neg_reg;
    logic [15:0] thr_reg;
    logic [15:0] last_mag_reg;
    logic        have_last_reg;

    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic [30:0] sx_reg, sy_reg, sz_reg;
    logic [1:0]  job_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [47:0] rad_reg;
    logic [25:0] rem_reg;
    logic [23:0] root_reg;
    logic [15:0] mag_reg;
    logic [23:0] perp_t_reg, perp_p_reg;

    logic signed [27:0] cx_reg, cy_reg;
    logic signed [28:0] cz_reg;
    logic [14:0] tilt_reg;
    logic signed [14:0] pitch_reg;
    logic signed [15:0] roll_reg;

    logic        out_valid_reg;
    logic [71:0] out_data_reg;
    logic        finish_fire;

    // shared multiplier
    logic signed [15:0] mul_op;
    logic signed [31:0] mul_sq;

    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0:    mul_op = ax_reg;
            2'd1:    mul_op = ay_reg;
            default: mul_op = az_reg;
        endcase
        mul_sq = mul_op * mul_op;
    end

    // square-root step and radicand selection
    logic [31:0] sum_all, sum_yz, others;
    logic [27:0] rem_sh, trial;
    logic        root_take;

    always_comb
    begin
        sum_all = 32'(sx_reg) + 32'(sy_reg) + 32'(sz_reg);
        sum_yz  = 32'(sy_reg) + 32'(sz_reg);
        unique case (axis_reg)
            AXIS_X:  others = sum_yz;
            AXIS_Y:  others = 32'(sx_reg) + 32'(sz_reg);
            default: others = 32'(sx_reg) + 32'(sy_reg);
        endcase
        rem_sh    = {rem_reg, rad_reg[47:46]};
        trial     = {2'b00, root_reg, 2'b01};
        root_take = (rem_sh >= trial);
    end

    // CORDIC operands
    logic signed [16:0] dot, dot_axis, neg_x;
    logic signed [24:0] num, den;

    always_comb
    begin
        unique case (axis_reg)
            AXIS_X:  dot_axis = 17'(ax_reg);
            AXIS_Y:  dot_axis = 17'(ay_reg);
            default: dot_axis = 17'(az_reg);
        endcase
        dot   = neg_reg ? -dot_axis : dot_axis;
        neg_x = -(17'(ax_reg));
        unique case (job_reg)
            2'd0:
            begin
                num = $signed({1'b0, perp_t_reg});
                den = $signed({dot, 8'b0});
            end
            2'd1:
            begin
                num = $signed({neg_x, 8'b0});
                den = $signed({1'b0, perp_p_reg});
            end
            default:
            begin
                num = $signed({ay_reg[15], ay_reg, 8'b0});
                den = $signed({az_reg[15], az_reg, 8'b0});
            end
        endcase
    end

    logic signed [27:0] num_w, den_w, xs, ys;
    logic signed [28:0] atan_step;

    always_comb
    begin
        num_w     = 28'(num);
        den_w     = 28'(den);
        xs        = cx_reg >>> cnt_reg;
        ys        = cy_reg >>> cnt_reg;
        atan_step = $signed({4'b0, atan_entry(cnt_reg)});
    end

    // round to nearest, halves away from zero, then clamp
    logic [28:0] zabs, zrnd;
    logic signed [17:0] rval, rlo, rhi, rclamp;

    always_comb
    begin
        zabs = cz_reg[28] ? 29'(-cz_reg) : 29'(cz_reg);
        zrnd = zabs + 29'd2048;
        rval = cz_reg[28] ? -$signed({1'b0, zrnd[28:12]}) : $signed({1'b0, zrnd[28:12]});
        unique case (job_reg)
            2'd0:
            begin
                rlo = 18'sd0;
                rhi = 18'sd18000;
            end
            2'd1:
            begin
                rlo = -18'sd9000;
                rhi = 18'sd9000;
            end
            default:
            begin
                rlo = -18'sd18000;
                rhi = 18'sd18000;
            end
        endcase
        if (rval < rlo)
            rclamp = rlo;
        else if (rval > rhi)
            rclamp = rhi;
        else
            rclamp = rval;
    end

    // position code and vibration
    logic [16:0] abs_x, abs_y, abs_z, th;
    logic [3:0]  position;
    logic        tilt_ok;
    logic [15:0] vib;

    always_comb
    begin
        abs_x = ax_reg[15] ? 17'(-17'(ax_reg)) : 17'(ax_reg);
        abs_y = ay_reg[15] ? 17'(-17'(ay_reg)) : 17'(ay_reg);
        abs_z = az_reg[15] ? 17'(-17'(az_reg)) : 17'(az_reg);
        th    = {1'b0, thr_reg};
        priority if (abs_z >= abs_x && abs_z >= abs_y && abs_z >= th)
        begin
            if (axis_reg != AXIS_X && axis_reg != AXIS_Y)
                position = ((neg_reg ? (az_reg <= 0) : (az_reg >= 0)))
                           ? POS_UPRIGHT : POS_INVERTED;
            else
                position = az_reg[15] ? POS_Z_NEG : POS_Z_POS;
        end
        else if (abs_x >= abs_y && abs_x >= abs_z && abs_x >= th)
        begin
            if (axis_reg == AXIS_X)
                position = ((neg_reg ? (ax_reg <= 0) : (ax_reg >= 0)))
                           ? POS_UPRIGHT : POS_INVERTED;
            else
                position = ax_reg[15] ? POS_X_NEG : POS_X_POS;
        end
        else if (abs_y >= abs_x && abs_y >= abs_z && abs_y >= th)
        begin
            if (axis_reg == AXIS_Y)
                position = ((neg_reg ? (ay_reg <= 0) : (ay_reg >= 0)))
                           ? POS_UPRIGHT : POS_INVERTED;
            else
                position = ay_reg[15] ? POS_Y_NEG : POS_Y_POS;
        end
        else
        begin
            position = POS_TILTED;
        end
        tilt_ok = (mag_reg != 16'd0);
        if (!have_last_reg)
            vib = 16'd0;
        else if (mag_reg >= last_mag_reg)
            vib = mag_reg - last_mag_reg;
        else
            vib = last_mag_reg - mag_reg;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    // hold the finished sample until the output register is free
    assign finish_fire   = (state_reg == ST_FINISH) && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= AXIS_RESET;
            neg_reg       <= 1'b0;
            thr_reg       <= THRESHOLD_RESET;
            last_mag_reg  <= 16'd0;
            have_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            ax_reg <= '0;  ay_reg <= '0;  az_reg <= '0;
            sx_reg <= '0;  sy_reg <= '0;  sz_reg <= '0;
            job_reg <= '0; cnt_reg <= '0;
            rad_reg <= '0; rem_reg <= '0; root_reg <= '0; mag_reg <= '0;
            perp_t_reg <= '0; perp_p_reg <= '0;
            cx_reg <= '0; cy_reg <= '0; cz_reg <= '0;
            tilt_reg <= '0; pitch_reg <= '0; roll_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_NORMAL_AXIS:     axis_reg <= cfg_data[1:0];
                    REG_NORMAL_NEGATIVE: neg_reg  <= cfg_data[0];
                    REG_THRESHOLD:       thr_reg  <= cfg_data;
                    default:             ;
                endcase
            end

            if (finish_fire)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        ax_reg    <= $signed(s_axis_tdata[15:0]);
                        ay_reg    <= $signed(s_axis_tdata[31:16]);
                        az_reg    <= $signed(s_axis_tdata[47:32]);
                        cnt_reg   <= '0;
                        state_reg <= ST_SQUARE;
                    end
                end
                ST_SQUARE:
                begin
                    unique case (cnt_reg[1:0])
                        2'd0:    sx_reg <= mul_sq[30:0];
                        2'd1:    sy_reg <= mul_sq[30:0];
                        default: sz_reg <= mul_sq[30:0];
                    endcase
                    if (cnt_reg == CNT_W'(2))
                    begin
                        job_reg   <= 2'd0;
                        state_reg <= ST_ROOT_LOAD;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ST_ROOT_LOAD:
                begin
                    unique case (job_reg)
                        2'd0:    rad_reg <= {16'b0, sum_all};
                        2'd1:    rad_reg <= {others, 16'b0};
                        default: rad_reg <= {sum_yz, 16'b0};
                    endcase
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_ROOT_STEP;
                end
                ST_ROOT_STEP:
                begin
                    rad_reg <= {rad_reg[45:0], 2'b00};
                    if (root_take)
                    begin
                        rem_reg  <= 26'(rem_sh - trial);
                        root_reg <= {root_reg[22:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh[25:0];
                        root_reg <= {root_reg[22:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    // land the finished root; the last step's bit is folded in here
                    if (cnt_reg == ROOT_LAST)
                    begin
                        unique case (job_reg)
                            2'd0:    mag_reg    <= {root_reg[14:0], root_take};
                            2'd1:    perp_t_reg <= {root_reg[22:0], root_take};
                            default: perp_p_reg <= {root_reg[22:0], root_take};
                        endcase
                        if (job_reg == 2'd2)
                        begin
                            job_reg   <= 2'd0;
                            state_reg <= ST_ROT_LOAD;
                        end
                        else
                        begin
                            job_reg   <= job_reg + 1'b1;
                            state_reg <= ST_ROOT_LOAD;
                        end
                    end
                end
                ST_ROT_LOAD:
                begin
                    cnt_reg <= '0;
                    if (num == 25'sd0 && !den[24])
                    begin
                        cz_reg    <= '0;
                        state_reg <= ST_ROT_DONE;
                    end
                    else
                    begin
                        if (den[24])
                        begin
                            if (!num[24])
                            begin
                                cx_reg <= num_w;
                                cy_reg <= -den_w;
                                cz_reg <= DEG90;
                            end
                            else
                            begin
                                cx_reg <= -num_w;
                                cy_reg <= den_w;
                                cz_reg <= -DEG90;
                            end
                        end
                        else
                        begin
                            cx_reg <= den_w;
                            cy_reg <= num_w;
                            cz_reg <= '0;
                        end
                        state_reg <= ST_ROT_STEP;
                    end
                end
                ST_ROT_STEP:
                begin
                    if (!cy_reg[27])
                    begin
                        cx_reg <= cx_reg + ys;
                        cy_reg <= cy_reg - xs;
                        cz_reg <= cz_reg + atan_step;
                    end
                    else
                    begin
                        cx_reg <= cx_reg - ys;
                        cy_reg <= cy_reg + xs;
                        cz_reg <= cz_reg - atan_step;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == ROT_LAST)
                        state_reg <= ST_ROT_DONE;
                end
                ST_ROT_DONE:
                begin
                    unique case (job_reg)
                        2'd0:    tilt_reg  <= rclamp[14:0];
                        2'd1:    pitch_reg <= rclamp[14:0];
                        default: roll_reg  <= rclamp[15:0];
                    endcase
                    if (job_reg == 2'd2)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        job_reg   <= job_reg + 1'b1;
                        state_reg <= ST_ROT_LOAD;
                    end
                end
                ST_FINISH:
                begin
                    if (finish_fire)
                    begin
                        out_data_reg  <= {5'b0, vib, position, roll_reg, pitch_reg,
                                          tilt_ok, tilt_ok ? tilt_reg : 15'd0};
                        last_mag_reg  <= mag_reg;
                        have_last_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
